// ----- src/ir_pulse_capture_fifo_unit_macros.svh -----
// Assertion macros used by the checker file of the infrared capture FIFO.
`ifndef IR_PULSE_CAPTURE_FIFO_UNIT_MACROS_SVH
`define IR_PULSE_CAPTURE_FIFO_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define IPCF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipcf assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define IPCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipcf assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define IPCF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ipcf assertion failed");

`endif

// ----- src/ipcf_pkg.sv -----
// Shared constants and types of the infrared capture FIFO.
package ipcf_pkg;

  localparam int RING_DEPTH = 512;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = 9;
  localparam int RAW_W      = 16;
  localparam int DUR_W      = 24;
  localparam int SCALED_W   = RAW_W + 2;
  localparam int PROD_W     = 2 * SCALED_W;
  localparam int QUOT_W     = 17;
  localparam int RECIP_SHIFT = 19;

  localparam logic [SCALED_W-1:0] RECIP_3      = SCALED_W'(174763);
  localparam logic [RAW_W-1:0]    OVERFLOW_RAW = 16'hFFFF;
  localparam logic [DUR_W-1:0]    DUR_MAX      = 24'hFFFFFF;
  localparam logic [DUR_W-1:0]    PULSE_DUR_MAX = 24'd87378;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic             pulse;
    logic [DUR_W-1:0] dur;
  } entry_t;

endpackage

// ----- src/ipcf_duration_conv.sv -----
// Converts a raw receiver count into a tagged ring entry in microseconds.
module ipcf_duration_conv
  import ipcf_pkg::*;
(
  input  logic [RAW_W-1:0] raw_duration,
  input  logic             space_phase,
  output entry_t           entry,
  output logic             toggle
);

  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;

  // Dividing by three is done as a multiplication by a rounded-up reciprocal.
  assign scaled = {raw_duration, 2'b00};
  assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_3);
  assign quot   = prod[RECIP_SHIFT +: QUOT_W];

  always_comb begin
    if (raw_duration == OVERFLOW_RAW) begin
      entry.pulse = 1'b0;
      entry.dur   = DUR_MAX;
      toggle      = 1'b0;
    end else begin
      entry.pulse = ~space_phase;
      entry.dur   = DUR_W'(quot);
      toggle      = 1'b1;
    end
  end

endmodule

// ----- src/ir_pulse_capture_fifo_unit.sv -----
// Top level of the infrared capture FIFO: input stage, ring memory and result stage.
//
// Usage: the input channel (in_valid, in_ready) carries one transaction per item:
// mode selects a push of raw_duration or a pop of the oldest entry, and
// first_of_transfer restarts the pulse/space phase on a push. The output channel
// (out_valid, out_ready) returns exactly one result per item, in order, with the
// popped duration, its pulse tag, an empty flag and the fill count afterwards.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets capture
// enable; it is always ready and should be written only while the block is idle.
// An accepted transaction moves from the input stage register to the result stage
// register. One item is accepted every cycle while the receiver takes results,
// as each item needs a single ring access with a registered read.
// When the receiver stalls, the result stage and memory read register hold and
// in_ready falls once the input stage is occupied. Reset empties the ring by
// clearing both pointers, sets the phase to pulse, disables capture and clears
// both stages; the entry memory itself is not cleared.
module ir_pulse_capture_fifo_unit
  import ipcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [RAW_W-1:0]  raw_duration,
  input  logic              first_of_transfer,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUR_W-1:0]  duration_us,
  output logic              is_pulse,
  output logic              was_empty,
  output logic [FILL_W-1:0] fill_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  function automatic logic [FILL_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + (PTR_W+1)'(RING_DEPTH);
    end
    return FILL_W'(d);
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic capture_enable;

  logic             s1_valid;
  logic             s1_mode;
  logic [RAW_W-1:0] s1_raw;
  logic             s1_first;

  logic              s2_valid;
  logic              s2_pop_ok;
  logic              s2_empty;
  logic [FILL_W-1:0] s2_fill;

  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic             space_phase, space_phase_next;

  entry_t ring_mem [RING_DEPTH];
  entry_t read_data;
  entry_t conv_entry;
  logic   conv_toggle;
  logic   phase_eff;

  logic advance, s1_fire, do_push, do_pop, ring_nonempty;

  assign advance       = ~s2_valid | out_ready;
  assign in_ready      = ~s1_valid | advance;
  assign s1_fire       = s1_valid & advance;
  assign ring_nonempty = (write_pointer != read_pointer);
  assign do_push       = s1_fire & (s1_mode == MODE_PUSH) & capture_enable;
  assign do_pop        = s1_fire & (s1_mode == MODE_POP) & ring_nonempty;
  assign phase_eff     = s1_first ? 1'b0 : space_phase;
  assign cfg_ready     = 1'b1;

  ipcf_duration_conv u_conv (
    .raw_duration (s1_raw),
    .space_phase  (phase_eff),
    .entry        (conv_entry),
    .toggle       (conv_toggle)
  );

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    space_phase_next   = space_phase;
    if (do_push) begin
      write_pointer_next = ring_next(write_pointer);
      space_phase_next   = conv_toggle ? ~phase_eff : phase_eff;
    end
    if (do_pop) begin
      read_pointer_next = ring_next(read_pointer);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      write_pointer  <= '0;
      read_pointer   <= '0;
      space_phase    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capture_enable <= cfg_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        s2_valid <= s1_valid;
      end
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      space_phase   <= space_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= mode;
      s1_raw   <= raw_duration;
      s1_first <= first_of_transfer;
    end
    if (s1_fire) begin
      s2_pop_ok <= (s1_mode == MODE_POP) & ring_nonempty;
      s2_empty  <= (s1_mode == MODE_POP) & ~ring_nonempty;
      s2_fill   <= ring_fill(write_pointer_next, read_pointer_next);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ring_mem[write_pointer] <= conv_entry;
    end
    if (do_pop) begin
      read_data <= ring_mem[read_pointer];
    end
  end

  assign out_valid   = s2_valid;
  assign duration_us = s2_pop_ok ? read_data.dur : '0;
  assign is_pulse    = s2_pop_ok & read_data.pulse;
  assign was_empty   = s2_empty;
  assign fill_count  = s2_fill;

endmodule

// ----- src/ipcf_checker.sv -----
// Port-level assertions for the infrared capture FIFO and their binding.
`include "ir_pulse_capture_fifo_unit_macros.svh"

module ipcf_checker
  import ipcf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUR_W-1:0]  duration_us,
  input logic              is_pulse,
  input logic              was_empty,
  input logic [FILL_W-1:0] fill_count
);

  `IPCF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(duration_us) && $stable(is_pulse) && $stable(fill_count))
  `IPCF_ASSERT_SAME(a_empty_result, clk, rst, out_valid && was_empty, duration_us == '0 && !is_pulse && fill_count == '0)
  `IPCF_ASSERT_SAME(a_long_is_overflow, clk, rst, out_valid && duration_us > PULSE_DUR_MAX, duration_us == DUR_MAX && !is_pulse)
  `IPCF_ASSERT_ALWAYS_NEXT(a_reset_clears, clk, rst, !out_valid)

endmodule

bind ir_pulse_capture_fifo_unit ipcf_checker u_ipcf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .duration_us (duration_us),
  .is_pulse    (is_pulse),
  .was_empty   (was_empty),
  .fill_count  (fill_count)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the infrared capture FIFO with its own ring predictor.
`timescale 1ns / 1ps

module testbench;
  import ipcf_pkg::*;

  typedef struct packed {
    logic             op;
    logic [RAW_W-1:0] raw;
    logic             first;
  } ir_cmd_t;

  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic              pulse;
    logic              empty;
    logic [FILL_W-1:0] fill;
  } readout_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              mode = MODE_PUSH;
  logic [RAW_W-1:0]  raw_duration = '0;
  logic              first_of_transfer = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DUR_W-1:0]  duration_us;
  logic              is_pulse;
  logic              was_empty;
  logic [FILL_W-1:0] fill_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  ir_cmd_t  queued_commands[$];
  readout_t expected_readouts[$];
  logic     in_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;

  entry_t           ring_mem [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             space_next;
  logic             capture_on;

  ir_pulse_capture_fifo_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .raw_duration      (raw_duration),
    .first_of_transfer (first_of_transfer),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .duration_us       (duration_us),
    .is_pulse          (is_pulse),
    .was_empty         (was_empty),
    .fill_count        (fill_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic readout_t predict_readout(input logic op, input logic [RAW_W-1:0] raw,
                                               input logic first);
    readout_t         r;
    entry_t           e;
    logic [RAW_W+1:0] scaled;
    r = '0;
    if (op == MODE_PUSH) begin
      if (capture_on) begin
        if (first) begin
          space_next = 1'b0;
        end
        if (raw == OVERFLOW_RAW) begin
          e.pulse = 1'b0;
          e.dur   = DUR_MAX;
        end else begin
          scaled     = {raw, 2'b00};
          e.dur      = DUR_W'(scaled / 3);
          e.pulse    = ~space_next;
          space_next = ~space_next;
        end
        ring_mem[wr_ptr] = e;
        wr_ptr = wr_ptr + 1'b1;
      end
    end else if (wr_ptr == rd_ptr) begin
      r.empty = 1'b1;
    end else begin
      e       = ring_mem[rd_ptr];
      r.dur   = e.dur;
      r.pulse = e.pulse;
      rd_ptr  = rd_ptr + 1'b1;
    end
    r.fill = FILL_W'(wr_ptr - rd_ptr);
    return r;
  endfunction

  always @(negedge clk) begin : command_drive
    ir_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_commands.pop_front();
        in_valid          <= 1'b1;
        mode              <= nxt.op;
        raw_duration      <= nxt.raw;
        first_of_transfer <= nxt.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    readout_t want;
    if (rst) begin
      in_taken   <= 1'b0;
      wr_ptr     = '0;
      rd_ptr     = '0;
      space_next = 1'b0;
      capture_on = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readouts.size() == 0) begin
          $error("result transaction arrived with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          if (duration_us !== want.dur) begin
            $error("duration_us: expected %0d, actual %0d", want.dur, duration_us);
            mismatches++;
          end
          if (is_pulse !== want.pulse) begin
            $error("is_pulse: expected %0d, actual %0d", want.pulse, is_pulse);
            mismatches++;
          end
          if (was_empty !== want.empty) begin
            $error("was_empty: expected %0d, actual %0d", want.empty, was_empty);
            mismatches++;
          end
          if (fill_count !== want.fill) begin
            $error("fill_count: expected %0d, actual %0d", want.fill, fill_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capture_on = cfg_data;
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_readouts.push_back(predict_readout(mode, raw_duration, first_of_transfer));
      end
    end
  end

  task automatic queue_cmd(input logic op, input logic [RAW_W-1:0] raw, input logic first);
    ir_cmd_t c;
    c.op    = op;
    c.raw   = raw;
    c.first = first;
    queued_commands.push_back(c);
  endtask

  task automatic drain();
    while (queued_commands.size() != 0 || in_valid) @(posedge clk);
    while (expected_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_capture(input logic en);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input logic en,
                              input int count, input int push_pct);
    int               burst_left;
    logic [RAW_W-1:0] raw;
    burst_left = 0;
    write_capture(en);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: raw = OVERFLOW_RAW;
        1: raw = RAW_W'($urandom_range(3));
        2: raw = 16'hFFFE - RAW_W'($urandom_range(3));
        default: raw = RAW_W'($urandom);
      endcase
      if ($urandom_range(99) < push_pct) begin
        if (burst_left == 0) begin
          queue_cmd(MODE_PUSH, raw, 1'b1);
          burst_left = $urandom_range(12, 1);
        end else begin
          queue_cmd(MODE_PUSH, raw, ($urandom_range(19) == 0));
        end
        burst_left--;
      end else begin
        queue_cmd(MODE_POP, raw, $urandom_range(1));
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Capture is off after reset: pushes are dropped and pops find nothing.
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    queue_cmd(MODE_PUSH, 16'h1234, 1'b1);
    queue_cmd(MODE_POP, 16'hFFFF, 1'b1);
    drain();

    write_capture(1'b1);
    queue_cmd(MODE_PUSH, 16'h0000, 1'b1);
    queue_cmd(MODE_PUSH, 16'h0001, 1'b0);
    queue_cmd(MODE_PUSH, 16'h0002, 1'b0);
    queue_cmd(MODE_PUSH, 16'h0003, 1'b0);
    queue_cmd(MODE_PUSH, OVERFLOW_RAW, 1'b0);
    queue_cmd(MODE_PUSH, 16'hFFFE, 1'b0);
    queue_cmd(MODE_PUSH, 16'h8000, 1'b1);
    queue_cmd(MODE_PUSH, 16'h7FFF, 1'b0);
    for (int i = 0; i < 8; i++) begin
      queue_cmd(MODE_POP, 16'hFFFF, i[0]);
    end
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    drain();

    // A dropped push must leave the phase alone.
    write_capture(1'b0);
    queue_cmd(MODE_PUSH, 16'h00AA, 1'b0);
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    drain();
    write_capture(1'b1);
    queue_cmd(MODE_PUSH, 16'h0055, 1'b0);
    queue_cmd(MODE_PUSH, 16'h0056, 1'b0);
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    drain();

    // Fill the ring past its depth so that the head overwrites and one entry is left.
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    for (int i = 0; i < RING_DEPTH + 1; i++) begin
      queue_cmd(MODE_PUSH, RAW_W'($urandom), (i % 64) == 0);
    end
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    queue_cmd(MODE_POP, 16'h0000, 1'b0);
    drain();

    random_phase(0, 0, 1'b1, 260, 55);
    random_phase(83, 0, 1'b1, 240, 65);
    random_phase(0, 83, 1'b0, 150, 50);
    random_phase(21, 21, 1'b1, 260, 75);
    random_phase(0, 0, 1'b1, 240, 40);
    random_phase(0, 83, 1'b1, 180, 60);
    random_phase(83, 0, 1'b0, 80, 50);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
